@@ rtl/stc_pkg.sv @@
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, register indexes and shift helpers for the trim
// compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

  localparam int DIV_W = 64;

  localparam logic [2:0] CFG_TEMP_TRIM    = 3'd0;
  localparam logic [2:0] CFG_PRESS_TRIM_A = 3'd1;
  localparam logic [2:0] CFG_PRESS_TRIM_B = 3'd2;
  localparam logic [2:0] CFG_PRESS_TRIM_C = 3'd3;
  localparam logic [2:0] CFG_HUM_TRIM_A   = 3'd4;
  localparam logic [2:0] CFG_HUM_TRIM_B   = 3'd5;

  // sideband that rides along the divider
  typedef struct packed {
    logic        neg;
    logic        nz;
    logic [31:0] tc;
    logic [16:0] hq;
  } stc_tag_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    logic signed [31:0] sx;
    sx = x;
    return sx >>> n;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    logic signed [63:0] sx;
    sx = x;
    return sx >>> n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/stc_div.sv @@
// ----------------------------------------------------------------------------
// stc_div
// Unsigned restoring divider, one quotient bit per pipeline stage, with a
// sideband tag carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module stc_div import stc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [DIV_W-1:0] in_num,
  input  wire logic [DIV_W-1:0] in_den,
  input  wire stc_tag_t         in_tag,
  output logic                  out_valid,
  output logic [DIV_W-1:0]      out_quo,
  output stc_tag_t              out_tag
);

  logic             vld [0:DIV_W-1];
  logic [DIV_W-1:0] rem [0:DIV_W-1];
  logic [DIV_W-1:0] num [0:DIV_W-1];
  logic [DIV_W-1:0] quo [0:DIV_W-1];
  logic [DIV_W-1:0] den [0:DIV_W-1];
  stc_tag_t         tag [0:DIV_W-1];

  for (genvar i = 0; i < DIV_W; i++) begin : g_stage
    logic             vld_in;
    logic [DIV_W-1:0] rem_in, num_in, quo_in, den_in;
    stc_tag_t         tag_in;
    logic [DIV_W:0]   part;
    logic [DIV_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = '0;
      assign num_in = in_num;
      assign quo_in = '0;
      assign den_in = in_den;
      assign tag_in = in_tag;
    end else begin : g_next
      assign vld_in = vld[i-1];
      assign rem_in = rem[i-1];
      assign num_in = num[i-1];
      assign quo_in = quo[i-1];
      assign den_in = den[i-1];
      assign tag_in = tag[i-1];
    end

    assign part = {rem_in, num_in[DIV_W-1]};
    assign ge   = (part >= {1'b0, den_in});
    assign diff = part - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= vld_in;
      end
      rem[i] <= ge ? diff[DIV_W-1:0] : part[DIV_W-1:0];
      num[i] <= {num_in[DIV_W-2:0], 1'b0};
      quo[i] <= {quo_in[DIV_W-2:0], ge};
      den[i] <= den_in;
      tag[i] <= tag_in;
    end
  end

  assign out_valid = vld[DIV_W-1];
  assign out_quo   = quo[DIV_W-1];
  assign out_tag   = tag[DIV_W-1];

endmodule

`default_nettype wire

@@ rtl/sensor_trim_compensation_top.sv @@
// ----------------------------------------------------------------------------
// sensor_trim_compensation_top
// Integer trim compensation of raw temperature, pressure and humidity.
// ----------------------------------------------------------------------------
// One reading set enters per clock whenever start is high; busy stays low.
// Each item produces one result, flagged by done for one cycle, after it has
// passed 12 stages of temperature, humidity and pressure pre-processing,
// 64 stages of the bit-per-stage pressure divider, then 6 stages of
// pressure post-correction. The result cannot be held off.
// Trims go in through cfg_valid / cfg_index / cfg_data, always ready; write
// them only while no items are in flight.
`default_nettype none

module sensor_trim_compensation_top import stc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [19:0] raw_temp,
  input  wire logic [19:0] raw_press,
  input  wire logic [15:0] raw_hum,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  output logic             done,
  output logic signed [31:0] temp_centi,
  output logic [31:0]      press_q8,
  output logic [16:0]      hum_q10
);

  logic [47:0] temp_trim, press_trim_a, press_trim_b, press_trim_c;
  logic [31:0] hum_trim_a;
  logic [39:0] hum_trim_b;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim    <= '0;
      press_trim_a <= '0;
      press_trim_b <= '0;
      press_trim_c <= '0;
      hum_trim_a   <= '0;
      hum_trim_b   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TEMP_TRIM:    temp_trim    <= cfg_data;
        CFG_PRESS_TRIM_A: press_trim_a <= cfg_data;
        CFG_PRESS_TRIM_B: press_trim_b <= cfg_data;
        CFG_PRESS_TRIM_C: press_trim_c <= cfg_data;
        CFG_HUM_TRIM_A:   hum_trim_a   <= cfg_data[31:0];
        CFG_HUM_TRIM_B:   hum_trim_b   <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  // trim fields
  logic [15:0]        tt1;
  logic [31:0]        tt2, tt3;
  logic [15:0]        pt1;
  logic signed [15:0] pt2, pt3, pt5, pt6, pt8, pt9;
  logic [15:0]        pt4, pt7;
  logic [31:0]        pt6_32, pt3_32, pt8_32, pt9_32;
  logic [7:0]         ht1, ht3;
  logic [31:0]        ht2, ht4, ht5, ht6;

  assign tt1    = temp_trim[15:0];
  assign tt2    = {{16{temp_trim[31]}}, temp_trim[31:16]};
  assign tt3    = {{16{temp_trim[47]}}, temp_trim[47:32]};
  assign pt1    = press_trim_a[15:0];
  assign pt2    = press_trim_a[31:16];
  assign pt3    = press_trim_a[47:32];
  assign pt4    = press_trim_b[15:0];
  assign pt5    = press_trim_b[31:16];
  assign pt6    = press_trim_b[47:32];
  assign pt7    = press_trim_c[15:0];
  assign pt8    = press_trim_c[31:16];
  assign pt9    = press_trim_c[47:32];
  assign pt3_32 = {{16{pt3[15]}}, pt3};
  assign pt6_32 = {{16{pt6[15]}}, pt6};
  assign pt8_32 = {{16{pt8[15]}}, pt8};
  assign pt9_32 = {{16{pt9[15]}}, pt9};
  assign ht1    = hum_trim_a[7:0];
  assign ht2    = {{16{hum_trim_a[23]}}, hum_trim_a[23:8]};
  assign ht3    = hum_trim_a[31:24];
  assign ht4    = {{16{hum_trim_b[15]}}, hum_trim_b[15:0]};
  assign ht5    = {{16{hum_trim_b[31]}}, hum_trim_b[31:16]};
  assign ht6    = {{24{hum_trim_b[39]}}, hum_trim_b[39:32]};

  // ---------------- stage 1: temperature products
  logic        s1_v;
  logic [31:0] s1_m1, s1_dd;
  logic [19:0] s1_ap;
  logic [15:0] s1_ah;
  logic [31:0] d1, d2;

  assign d1 = {15'b0, raw_temp[19:3]} - {15'b0, tt1, 1'b0};
  assign d2 = {16'b0, raw_temp[19:4]} - {16'b0, tt1};

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else     s1_v <= start && !busy;
    s1_m1 <= d1 * tt2;
    s1_dd <= d2 * d2;
    s1_ap <= raw_press;
    s1_ah <= raw_hum;
  end

  // ---------------- stage 2
  logic        s2_v;
  logic [31:0] s2_v1, s2_m2;
  logic [19:0] s2_ap;
  logic [15:0] s2_ah;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else     s2_v <= s1_v;
    s2_v1 <= asr32(s1_m1, 11);
    s2_m2 <= asr32(s1_dd, 12) * tt3;
    s2_ap <= s1_ap;
    s2_ah <= s1_ah;
  end

  // ---------------- stage 3: fine temperature
  logic        s3_v;
  logic [31:0] s3_tf;
  logic [19:0] s3_ap;
  logic [15:0] s3_ah;

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else     s3_v <= s2_v;
    s3_tf <= s2_v1 + asr32(s2_m2, 14);
    s3_ap <= s2_ap;
    s3_ah <= s2_ah;
  end

  // ---------------- stage 4
  logic               s4_v;
  logic [63:0]        s4_aa;
  logic signed [49:0] s4_ap2, s4_ap5;
  logic [20:0]        s4_pp;
  logic [31:0]        s4_tc, s4_hxm, s4_hym, s4_hzm, s4_xs;
  logic signed [33:0] pa;
  logic signed [67:0] aa_full;
  logic [31:0]        hv;

  assign pa      = $signed({{2{s3_tf[31]}}, s3_tf}) - 34'sd128000;
  assign aa_full = pa * pa;
  assign hv      = s3_tf - 32'd76800;

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else     s4_v <= s3_v;
    s4_aa  <= aa_full[63:0];
    s4_ap2 <= pa * pt2;
    s4_ap5 <= pa * pt5;
    s4_pp  <= 21'd1048576 - {1'b0, s3_ap};
    s4_tc  <= asr32(s3_tf * 32'd5 + 32'd128, 8);
    s4_hxm <= ht5 * hv;
    s4_hym <= hv * ht6;
    s4_hzm <= hv * {24'b0, ht3};
    s4_xs  <= {2'b0, s3_ah, 14'b0} - (ht4 << 20) + 32'd16384;
  end

  // ---------------- stage 5: split 64 x 16 products
  logic               s5_v;
  logic signed [48:0] s5_p6lo, s5_p3lo;
  logic [31:0]        s5_p6hi, s5_p3hi;
  logic signed [49:0] s5_ap2, s5_ap5;
  logic [20:0]        s5_pp;
  logic [31:0]        s5_tc, s5_x, s5_y0, s5_z;

  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else     s5_v <= s4_v;
    s5_p6lo <= $signed({1'b0, s4_aa[31:0]}) * pt6;
    s5_p6hi <= s4_aa[63:32] * pt6_32;
    s5_p3lo <= $signed({1'b0, s4_aa[31:0]}) * pt3;
    s5_p3hi <= s4_aa[63:32] * pt3_32;
    s5_ap2  <= s4_ap2;
    s5_ap5  <= s4_ap5;
    s5_pp   <= s4_pp;
    s5_tc   <= s4_tc;
    s5_x    <= asr32(s4_xs - s4_hxm, 15);
    s5_y0   <= asr32(s4_hym, 10);
    s5_z    <= asr32(s4_hzm, 11) + 32'd32768;
  end

  // ---------------- stage 6
  logic        s6_v;
  logic [63:0] s6_b, s6_a2;
  logic [20:0] s6_pp;
  logic [31:0] s6_tc, s6_x, s6_y1;
  logic [63:0] p6_sum, p3_sum;

  assign p6_sum = {{15{s5_p6lo[48]}}, s5_p6lo} + {s5_p6hi, 32'b0};
  assign p3_sum = {{15{s5_p3lo[48]}}, s5_p3lo} + {s5_p3hi, 32'b0};

  always_ff @(posedge clk) begin
    if (rst) s6_v <= 1'b0;
    else     s6_v <= s5_v;
    s6_b  <= p6_sum + ({{14{s5_ap5[49]}}, s5_ap5} << 17) + ({{48{pt4[15]}}, pt4} << 35);
    s6_a2 <= asr64(p3_sum, 8) + ({{14{s5_ap2[49]}}, s5_ap2} << 12);
    s6_pp <= s5_pp;
    s6_tc <= s5_tc;
    s6_x  <= s5_x;
    s6_y1 <= asr32(s5_y0 * s5_z, 10) + 32'd2097152;
  end

  // ---------------- stage 7
  logic        s7_v;
  logic [47:0] s7_p1lo;
  logic [31:0] s7_p1hi;
  logic [63:0] s7_n0;
  logic [31:0] s7_tc, s7_x, s7_y2;
  logic [63:0] tsum;

  assign tsum = s6_a2 + 64'h0000_8000_0000_0000;

  always_ff @(posedge clk) begin
    if (rst) s7_v <= 1'b0;
    else     s7_v <= s6_v;
    s7_p1lo <= tsum[31:0] * pt1;
    s7_p1hi <= tsum[63:32] * {16'b0, pt1};
    s7_n0   <= ({43'b0, s6_pp} << 31) - s6_b;
    s7_tc   <= s6_tc;
    s7_x    <= s6_x;
    s7_y2   <= asr32(s6_y1 * ht2 + 32'd8192, 14);
  end

  // ---------------- stage 8
  logic        s8_v;
  logic [63:0] s8_a3;
  logic [43:0] s8_nlo;
  logic [31:0] s8_nhi, s8_tc, s8_hv;

  always_ff @(posedge clk) begin
    if (rst) s8_v <= 1'b0;
    else     s8_v <= s7_v;
    s8_a3  <= asr64({16'b0, s7_p1lo} + {s7_p1hi, 32'b0}, 33);
    s8_nlo <= s7_n0[31:0] * 12'd3125;
    s8_nhi <= s7_n0[63:32] * 32'd3125;
    s8_tc  <= s7_tc;
    s8_hv  <= s7_x * s7_y2;
  end

  // ---------------- stage 9
  logic        s9_v;
  logic [63:0] s9_num, s9_a3;
  logic [31:0] s9_tc, s9_hv, s9_sq, s15;

  assign s15 = asr32(s8_hv, 15);

  always_ff @(posedge clk) begin
    if (rst) s9_v <= 1'b0;
    else     s9_v <= s8_v;
    s9_num <= {20'b0, s8_nlo} + {s8_nhi, 32'b0};
    s9_a3  <= s8_a3;
    s9_tc  <= s8_tc;
    s9_hv  <= s8_hv;
    s9_sq  <= s15 * s15;
  end

  // ---------------- stage 10
  logic        s10_v;
  logic [63:0] s10_num, s10_a3;
  logic [31:0] s10_tc, s10_hv, s10_w;

  always_ff @(posedge clk) begin
    if (rst) s10_v <= 1'b0;
    else     s10_v <= s9_v;
    s10_num <= s9_num;
    s10_a3  <= s9_a3;
    s10_tc  <= s9_tc;
    s10_hv  <= s9_hv;
    s10_w   <= asr32(s9_sq, 7) * {24'b0, ht1};
  end

  // ---------------- stage 11: humidity clamp
  logic        s11_v;
  logic [63:0] s11_num, s11_a3;
  logic [31:0] s11_tc;
  logic [16:0] s11_hq;
  logic [31:0] hsub, hclamp;

  assign hsub = s10_hv - asr32(s10_w, 4);

  always_comb begin
    priority if (hsub[31])             hclamp = '0;
    else if (hsub > 32'd419430400)     hclamp = 32'd419430400;
    else                               hclamp = hsub;
  end

  always_ff @(posedge clk) begin
    if (rst) s11_v <= 1'b0;
    else     s11_v <= s10_v;
    s11_num <= s10_num;
    s11_a3  <= s10_a3;
    s11_tc  <= s10_tc;
    s11_hq  <= hclamp[28:12];
  end

  // ---------------- stage 12: magnitudes for the divider
  logic        s12_v;
  logic [63:0] s12_un, s12_ud;
  stc_tag_t    s12_tag;

  always_ff @(posedge clk) begin
    if (rst) s12_v <= 1'b0;
    else     s12_v <= s11_v;
    s12_un      <= s11_num[63] ? 64'd0 - s11_num : s11_num;
    s12_ud      <= s11_a3[63] ? 64'd0 - s11_a3 : s11_a3;
    s12_tag.neg <= s11_num[63] ^ s11_a3[63];
    s12_tag.nz  <= |s11_a3;
    s12_tag.tc  <= s11_tc;
    s12_tag.hq  <= s11_hq;
  end

  logic        dv_valid;
  logic [63:0] dv_quo;
  stc_tag_t    dv_tag;

  stc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s12_v),
    .in_num    (s12_un),
    .in_den    (s12_ud),
    .in_tag    (s12_tag),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_tag   (dv_tag)
  );

  // ---------------- post 1: signed quotient
  logic        r1_v;
  logic [63:0] r1_p;
  stc_tag_t    r1_tag;

  always_ff @(posedge clk) begin
    if (rst) r1_v <= 1'b0;
    else     r1_v <= dv_valid;
    r1_p   <= dv_tag.neg ? 64'd0 - dv_quo : dv_quo;
    r1_tag <= dv_tag;
  end

  // ---------------- post 2: p9*s and p8*p partials
  logic               r2_v;
  logic signed [48:0] r2_p9lo, r2_p8lo;
  logic [31:0]        r2_p9hi, r2_p8hi;
  logic [63:0]        r2_s, r2_p;
  stc_tag_t           r2_tag;
  logic [63:0]        ps;

  assign ps = asr64(r1_p, 13);

  always_ff @(posedge clk) begin
    if (rst) r2_v <= 1'b0;
    else     r2_v <= r1_v;
    r2_p9lo <= $signed({1'b0, ps[31:0]}) * pt9;
    r2_p9hi <= ps[63:32] * pt9_32;
    r2_p8lo <= $signed({1'b0, r1_p[31:0]}) * pt8;
    r2_p8hi <= r1_p[63:32] * pt8_32;
    r2_s    <= ps;
    r2_p    <= r1_p;
    r2_tag  <= r1_tag;
  end

  // ---------------- post 3
  logic        r3_v;
  logic [63:0] r3_p9s, r3_q2, r3_s, r3_p;
  stc_tag_t    r3_tag;

  always_ff @(posedge clk) begin
    if (rst) r3_v <= 1'b0;
    else     r3_v <= r2_v;
    r3_p9s <= {{15{r2_p9lo[48]}}, r2_p9lo} + {r2_p9hi, 32'b0};
    r3_q2  <= asr64({{15{r2_p8lo[48]}}, r2_p8lo} + {r2_p8hi, 32'b0}, 19);
    r3_s   <= r2_s;
    r3_p   <= r2_p;
    r3_tag <= r2_tag;
  end

  // ---------------- post 4: low 64 bits of (p9*s)*s
  logic        r4_v;
  logic [63:0] r4_ll, r4_p, r4_q2;
  logic [31:0] r4_lh, r4_hl;
  stc_tag_t    r4_tag;

  always_ff @(posedge clk) begin
    if (rst) r4_v <= 1'b0;
    else     r4_v <= r3_v;
    r4_ll  <= {32'b0, r3_p9s[31:0]} * {32'b0, r3_s[31:0]};
    r4_lh  <= r3_p9s[31:0] * r3_s[63:32];
    r4_hl  <= r3_p9s[63:32] * r3_s[31:0];
    r4_p   <= r3_p;
    r4_q2  <= r3_q2;
    r4_tag <= r3_tag;
  end

  // ---------------- post 5
  logic        r5_v;
  logic [63:0] r5_q1, r5_p, r5_q2;
  stc_tag_t    r5_tag;

  always_ff @(posedge clk) begin
    if (rst) r5_v <= 1'b0;
    else     r5_v <= r4_v;
    r5_q1  <= asr64(r4_ll + {r4_lh + r4_hl, 32'b0}, 25);
    r5_p   <= r4_p;
    r5_q2  <= r4_q2;
    r5_tag <= r4_tag;
  end

  // ---------------- post 6: final pressure and result register
  logic [63:0] pfin;

  assign pfin = asr64(r5_p + r5_q1 + r5_q2, 8) + ({{48{pt7[15]}}, pt7} << 4);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= r5_v;
    temp_centi <= r5_tag.tc;
    hum_q10    <= r5_tag.hq;
    press_q8   <= r5_tag.nz ? pfin[31:0] : 32'd0;
  end

endmodule

`default_nettype wire
